// ===== sv/plsimp_pkg.sv =====
`timescale 1ns / 1ps
// plsimp_pkg: shared types and constants of the polyline simplifier
// used by plsimp_mac and polyline_simplifier; no dependencies

package plsimp_pkg;

  localparam int COORD_W = 16;
  localparam int OP_W    = 20;
  localparam int PROD_W  = 2 * OP_W;
  localparam int ACC_W   = 72;
  localparam int NUM_W   = 70;
  localparam int EPS_W   = 32;
  localparam int LEN_W   = 34;
  localparam int CROSS_W = 35;

  typedef enum logic [1:0] {
    STAT_OK  = 2'd0,
    STAT_FEW = 2'd1,
    STAT_OVF = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SH0  = 3'd0,
    SH16 = 3'd1,
    SH18 = 3'd2,
    SH19 = 3'd3,
    SH34 = 3'd4,
    SH36 = 3'd5
  } shift_t;

  typedef struct packed {
    logic                   en;
    logic                   clr;
    logic                   sub;
    shift_t                 shift;
    logic signed [OP_W-1:0] a;
    logic signed [OP_W-1:0] b;
  } mac_cmd_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      point_last;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      out_last;
    logic [1:0]                status;
  } result_t;

endpackage

// ===== sv/plsimp_mac.sv =====
`timescale 1ns / 1ps
// plsimp_mac: shared signed multiply, shift and accumulate unit
// depends on plsimp_pkg

module plsimp_mac (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plsimp_pkg::mac_cmd_t              cmd,
  output logic signed [plsimp_pkg::ACC_W-1:0] acc
);

  logic signed [plsimp_pkg::PROD_W-1:0] prod_r;
  logic                                 en_r, clr_r, sub_r;
  plsimp_pkg::shift_t                   shift_r;
  logic signed [plsimp_pkg::ACC_W-1:0]  acc_r, acc_nxt, term_ext, term;

  // stage one: product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= cmd.en;
    end
    prod_r  <= cmd.a * cmd.b;
    clr_r   <= cmd.clr;
    sub_r   <= cmd.sub;
    shift_r <= cmd.shift;
  end

  assign term_ext = plsimp_pkg::ACC_W'(prod_r);

  always_comb begin
    case (shift_r)
      plsimp_pkg::SH0:  term = term_ext;
      plsimp_pkg::SH16: term = term_ext <<< 16;
      plsimp_pkg::SH18: term = term_ext <<< 18;
      plsimp_pkg::SH19: term = term_ext <<< 19;
      plsimp_pkg::SH34: term = term_ext <<< 34;
      plsimp_pkg::SH36: term = term_ext <<< 36;
      default:          term = term_ext;
    endcase
  end

  // stage two: accumulate
  always_comb begin
    acc_nxt = acc_r;
    if (en_r) begin
      if (sub_r) begin
        acc_nxt = (clr_r ? '0 : acc_r) - term;
      end else begin
        acc_nxt = (clr_r ? '0 : acc_r) + term;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

// ===== sv/polyline_simplifier.sv =====
`timescale 1ns / 1ps
// polyline_simplifier: top level, point store, segment stack and sequencer
// depends on plsimp_pkg and plsimp_mac
//
// usage: points of one polyline come in on the in_ channel, one request per
// cycle while in_stall is low; the request with point_last high closes the
// polyline. the block then raises in_stall and simplifies the line, walking a
// stack of segment ranges held in a small memory. each interior point uses
// the one shared multiply-accumulate unit (cross product, then its square in
// three partial products, or its squared distance from the start when the
// endpoints coincide); each segment also uses it for its length and its
// tolerance product. kept points leave on the out_ channel in order, the next
// only after the last is taken; out_last marks the final one. a polyline with
// fewer than two points or more than MAX_POINTS points gives a single request
// with an error status. a new polyline is accepted once the final result has
// been taken. cfg_we writes eps_sq (reset value 1); the user must do so only
// while the block is idle, the block does not enforce it. reset is synchronous
// and clears all control state; the point and stack memories need no clearing.

module polyline_simplifier #(
  parameter int MAX_POINTS = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  plsimp_pkg::point_t               in_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output plsimp_pkg::result_t              out_item,
  input  logic                             cfg_we,
  input  logic [plsimp_pkg::EPS_W-1:0]     cfg_wdata
);

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int XW = CW + 1;
  localparam int CDW = 2 * plsimp_pkg::COORD_W;
  localparam int DW = plsimp_pkg::COORD_W + 1;

  typedef enum logic [14:0] {
    S_LOAD  = 15'b000000000000001,
    S_ERR   = 15'b000000000000010,
    S_INIT  = 15'b000000000000100,
    S_POP   = 15'b000000000001000,
    S_SEG   = 15'b000000000010000,
    S_RDS   = 15'b000000000100000,
    S_RDE   = 15'b000000001000000,
    S_MAC   = 15'b000000010000000,
    S_PTRD  = 15'b000000100000000,
    S_PTD   = 15'b000001000000000,
    S_PUSH1 = 15'b000010000000000,
    S_PUSH2 = 15'b000100000000000,
    S_EMS   = 15'b001000000000000,
    S_EMR   = 15'b010000000000000,
    S_EMW   = 15'b100000000000000
  } state_t;

  typedef enum logic [2:0] {
    P_LEN   = 3'd0,
    P_DEG   = 3'd1,
    P_CROSS = 3'd2,
    P_SQ    = 3'd3,
    P_THR   = 3'd4
  } prog_t;

  state_t state_r, state_nxt;
  prog_t  prog_r, prog_nxt;
  logic [2:0] step_r, step_nxt, nops;

  logic [CW-1:0] cnt_r, cnt_nxt, n_r, n_nxt, top_r, top_nxt, j_r, j_nxt;
  logic          ovf_r, ovf_nxt;
  logic [MAX_POINTS-1:0] keep_r, keep_nxt;
  logic [IW-1:0] s_r, s_nxt, e_r, e_nxt, i_r, i_nxt, bidx_r, bidx_nxt;
  logic signed [plsimp_pkg::COORD_W-1:0] xs_r, xs_nxt, ys_r, ys_nxt;
  logic signed [DW-1:0] dx_r, dx_nxt, dy_r, dy_nxt, pvx_r, pvx_nxt, pvy_r, pvy_nxt;
  logic [plsimp_pkg::LEN_W-1:0]   len2_r, len2_nxt, len_eff;
  logic [plsimp_pkg::CROSS_W-1:0] c_r, c_nxt;
  logic [plsimp_pkg::NUM_W-1:0]   best_r, best_nxt, num;
  logic [plsimp_pkg::EPS_W-1:0]   eps_r;
  plsimp_pkg::result_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // point memory
  logic [CDW-1:0] cmem [MAX_POINTS];
  logic [CDW-1:0] c_rd_r;
  logic           c_we;
  logic [IW-1:0]  c_wa, c_ra;
  logic signed [plsimp_pkg::COORD_W-1:0] rd_x, rd_y;

  // segment stack memory, entry is {start, end}
  logic [2*IW-1:0] smem [MAX_POINTS];
  logic [2*IW-1:0] s_rd_r, s_wd;
  logic            s_we;
  logic [IW-1:0]   s_wa, s_ra, seg_s, seg_e;

  plsimp_pkg::mac_cmd_t cmd;
  logic signed [plsimp_pkg::ACC_W-1:0] acc;
  logic signed [plsimp_pkg::CROSS_W-1:0] cross_v;

  logic in_acc, out_acc;

  plsimp_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .acc   (acc)
  );

  always_ff @(posedge clk) begin
    if (c_we) begin
      cmem[c_wa] <= {in_point.point_x, in_point.point_y};
    end
    c_rd_r <= cmem[c_ra];
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_wa] <= s_wd;
    end
    s_rd_r <= smem[s_ra];
  end

  assign rd_x  = c_rd_r[CDW-1:plsimp_pkg::COORD_W];
  assign rd_y  = c_rd_r[plsimp_pkg::COORD_W-1:0];
  assign seg_s = s_rd_r[2*IW-1:IW];
  assign seg_e = s_rd_r[IW-1:0];

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign out_acc   = out_valid_r && !out_stall;

  assign len_eff = (len2_r == '0) ? plsimp_pkg::LEN_W'(1) : len2_r;
  assign cross_v = acc[plsimp_pkg::CROSS_W-1:0];
  assign num     = acc[plsimp_pkg::NUM_W-1:0];

  // operand program of the shared unit
  always_comb begin
    cmd       = '0;
    cmd.shift = plsimp_pkg::SH0;
    nops      = 3'd2;
    case (prog_r)
      P_LEN: begin
        nops = 3'd2;
        cmd.a = (step_r == 3'd0) ? plsimp_pkg::OP_W'(dx_r) : plsimp_pkg::OP_W'(dy_r);
        cmd.b = cmd.a;
      end
      P_DEG: begin
        nops = 3'd2;
        cmd.a = (step_r == 3'd0) ? plsimp_pkg::OP_W'(pvx_r) : plsimp_pkg::OP_W'(pvy_r);
        cmd.b = cmd.a;
      end
      P_CROSS: begin
        nops = 3'd2;
        if (step_r == 3'd0) begin
          cmd.a = plsimp_pkg::OP_W'(dx_r);
          cmd.b = plsimp_pkg::OP_W'(pvy_r);
        end else begin
          cmd.a   = plsimp_pkg::OP_W'(dy_r);
          cmd.b   = plsimp_pkg::OP_W'(pvx_r);
          cmd.sub = 1'b1;
        end
      end
      P_SQ: begin
        // square of the magnitude split into high 17 and low 18 bits
        nops = 3'd3;
        case (step_r)
          3'd0: begin
            cmd.a = $signed({3'b0, c_r[34:18]});
            cmd.b = $signed({3'b0, c_r[34:18]});
            cmd.shift = plsimp_pkg::SH36;
          end
          3'd1: begin
            cmd.a = $signed({3'b0, c_r[34:18]});
            cmd.b = $signed({2'b0, c_r[17:0]});
            cmd.shift = plsimp_pkg::SH19;
          end
          default: begin
            cmd.a = $signed({2'b0, c_r[17:0]});
            cmd.b = $signed({2'b0, c_r[17:0]});
          end
        endcase
      end
      P_THR: begin
        // eps_sq times segment length squared, four partial products
        nops = 3'd4;
        case (step_r)
          3'd0: begin
            cmd.a = $signed({4'b0, eps_r[31:16]});
            cmd.b = $signed({4'b0, len_eff[33:18]});
            cmd.shift = plsimp_pkg::SH34;
          end
          3'd1: begin
            cmd.a = $signed({4'b0, eps_r[31:16]});
            cmd.b = $signed({2'b0, len_eff[17:0]});
            cmd.shift = plsimp_pkg::SH16;
          end
          3'd2: begin
            cmd.a = $signed({4'b0, eps_r[15:0]});
            cmd.b = $signed({4'b0, len_eff[33:18]});
            cmd.shift = plsimp_pkg::SH18;
          end
          default: begin
            cmd.a = $signed({4'b0, eps_r[15:0]});
            cmd.b = $signed({2'b0, len_eff[17:0]});
          end
        endcase
      end
      default: nops = 3'd2;
    endcase
    cmd.en  = (state_r == S_MAC) && (step_r < nops);
    cmd.clr = (step_r == 3'd0);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    prog_nxt  = prog_r;
    step_nxt  = step_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    top_nxt   = top_r;
    j_nxt     = j_r;
    keep_nxt  = keep_r;
    s_nxt     = s_r;
    e_nxt     = e_r;
    i_nxt     = i_r;
    bidx_nxt  = bidx_r;
    xs_nxt    = xs_r;
    ys_nxt    = ys_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    pvx_nxt   = pvx_r;
    pvy_nxt   = pvy_r;
    len2_nxt  = len2_r;
    c_nxt     = c_r;
    best_nxt  = best_r;
    out_nxt   = out_r;
    out_valid_nxt = out_valid_r;
    c_we = 1'b0;
    c_wa = cnt_r[IW-1:0];
    c_ra = i_r;
    s_we = 1'b0;
    s_wa = top_r[IW-1:0];
    s_wd = {s_r, e_r};
    s_ra = top_r[IW-1:0] - IW'(1);

    if (out_acc) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (cnt_r >= CW'(MAX_POINTS)) begin
            ovf_nxt = 1'b1;
          end else begin
            c_we    = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end
          if (in_point.point_last) begin
            n_nxt = cnt_nxt;
            if (ovf_nxt || cnt_nxt < CW'(2)) begin
              out_nxt.out_x    = '0;
              out_nxt.out_y    = '0;
              out_nxt.out_last = 1'b1;
              out_nxt.status   = ovf_nxt ? plsimp_pkg::STAT_OVF : plsimp_pkg::STAT_FEW;
              out_valid_nxt    = 1'b1;
              state_nxt        = S_ERR;
            end else begin
              state_nxt = S_INIT;
            end
          end
        end
      end
      S_ERR: begin
        if (out_acc) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end
      end
      S_INIT: begin
        keep_nxt = '0;
        keep_nxt[0] = 1'b1;
        keep_nxt[n_r[IW-1:0] - IW'(1)] = 1'b1;
        s_we = 1'b1;
        s_wa = '0;
        s_wd = {IW'(0), n_r[IW-1:0] - IW'(1)};
        top_nxt   = CW'(1);
        state_nxt = S_POP;
      end
      S_POP: begin
        if (top_r == '0) begin
          j_nxt     = '0;
          state_nxt = S_EMS;
        end else begin
          top_nxt   = top_r - CW'(1);
          state_nxt = S_SEG;
        end
      end
      S_SEG: begin
        s_nxt = seg_s;
        e_nxt = seg_e;
        c_ra  = seg_s;
        if (XW'(seg_e) < XW'(seg_s) + XW'(2) || XW'(seg_e) >= XW'(n_r)) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_RDS;
        end
      end
      S_RDS: begin
        xs_nxt    = rd_x;
        ys_nxt    = rd_y;
        c_ra      = e_r;
        state_nxt = S_RDE;
      end
      S_RDE: begin
        dx_nxt    = DW'(rd_x) - DW'(xs_r);
        dy_nxt    = DW'(rd_y) - DW'(ys_r);
        prog_nxt  = P_LEN;
        step_nxt  = '0;
        state_nxt = S_MAC;
      end
      S_PTRD: begin
        c_ra      = i_r;
        state_nxt = S_PTD;
      end
      S_PTD: begin
        pvx_nxt   = DW'(rd_x) - DW'(xs_r);
        pvy_nxt   = DW'(rd_y) - DW'(ys_r);
        prog_nxt  = (len2_r == '0) ? P_DEG : P_CROSS;
        step_nxt  = '0;
        state_nxt = S_MAC;
      end
      S_MAC: begin
        step_nxt = step_r + 3'd1;
        // accumulator holds the result once the last issue has passed the product and accumulate registers
        if (step_r == nops + 3'd1) begin
          step_nxt = '0;
          case (prog_r)
            P_LEN: begin
              len2_nxt  = acc[plsimp_pkg::LEN_W-1:0];
              best_nxt  = '0;
              bidx_nxt  = '0;
              i_nxt     = s_r + IW'(1);
              state_nxt = S_PTRD;
            end
            P_CROSS: begin
              c_nxt    = (cross_v < 0) ? plsimp_pkg::CROSS_W'(-cross_v)
                                       : plsimp_pkg::CROSS_W'(cross_v);
              prog_nxt = P_SQ;
            end
            P_DEG, P_SQ: begin
              // strict compare keeps the first point of greatest distance
              if (num > best_r) begin
                best_nxt = num;
                bidx_nxt = i_r;
              end
              if (XW'(i_r) + XW'(1) < XW'(e_r)) begin
                i_nxt     = i_r + IW'(1);
                state_nxt = S_PTRD;
              end else begin
                prog_nxt = P_THR;
              end
            end
            P_THR: begin
              if (best_r > num) begin
                keep_nxt[bidx_r] = 1'b1;
                state_nxt = S_PUSH1;
              end else begin
                state_nxt = S_POP;
              end
            end
            default: state_nxt = S_POP;
          endcase
        end
      end
      S_PUSH1: begin
        if (top_r < CW'(MAX_POINTS)) begin
          s_we    = 1'b1;
          s_wd    = {bidx_r, e_r};
          top_nxt = top_r + CW'(1);
        end
        state_nxt = S_PUSH2;
      end
      S_PUSH2: begin
        if (top_r < CW'(MAX_POINTS)) begin
          s_we    = 1'b1;
          s_wd    = {s_r, bidx_r};
          top_nxt = top_r + CW'(1);
        end
        state_nxt = S_POP;
      end
      S_EMS: begin
        c_ra = j_r[IW-1:0];
        if (j_r == n_r) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_LOAD;
        end else if (keep_r[j_r[IW-1:0]]) begin
          state_nxt = S_EMR;
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      S_EMR: begin
        out_nxt.out_x    = rd_x;
        out_nxt.out_y    = rd_y;
        out_nxt.out_last = (j_r == n_r - CW'(1));
        out_nxt.status   = plsimp_pkg::STAT_OK;
        out_valid_nxt    = 1'b1;
        state_nxt        = S_EMW;
      end
      S_EMW: begin
        if (out_acc) begin
          j_nxt     = j_r + CW'(1);
          state_nxt = S_EMS;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      prog_r      <= P_LEN;
      step_r      <= '0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      top_r       <= '0;
      j_r         <= '0;
      keep_r      <= '0;
      best_r      <= '0;
      bidx_r      <= '0;
      out_valid_r <= 1'b0;
      eps_r       <= plsimp_pkg::EPS_W'(1);
    end else begin
      state_r     <= state_nxt;
      prog_r      <= prog_nxt;
      step_r      <= step_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      top_r       <= top_nxt;
      j_r         <= j_nxt;
      keep_r      <= keep_nxt;
      best_r      <= best_nxt;
      bidx_r      <= bidx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        eps_r <= cfg_wdata;
      end
    end
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    i_r    <= i_nxt;
    xs_r   <= xs_nxt;
    ys_r   <= ys_nxt;
    dx_r   <= dx_nxt;
    dy_r   <= dy_nxt;
    pvx_r  <= pvx_nxt;
    pvy_r  <= pvy_nxt;
    len2_r <= len2_nxt;
    c_r    <= c_nxt;
    out_r  <= out_nxt;
  end

  // results only leave from the error or emit wait states
  a_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_ERR || state_r == S_EMW))
    else $error("result valid outside an output state");

  // stack never grows past its depth
  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    top_r <= CW'(MAX_POINTS))
    else $error("segment stack overrun");

  // emission starts only with the stack drained and the first endpoint kept
  a_emit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMS) |-> (top_r == '0 && keep_r[0]))
    else $error("emit with pending segments");

  // the shared unit is only driven while sequencing
  a_mac_use: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.en |-> (state_r == S_MAC))
    else $error("multiply issued outside sequence");

endmodule
